// ===== src/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps
package tccw_pkg;

   localparam int SCREEN_COLUMNS_DEF = 80;
   localparam int SCREEN_ROWS_DEF    = 25;

   localparam int INDEX_W = 11;
   localparam int BYTE_W  = 8;
   localparam int CELL_W  = 2 * BYTE_W;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] BLANK_CHAR     = 8'h20;
   localparam logic [BYTE_W-1:0] BLANK_ATTR     = 8'h07;

   typedef enum logic [1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCROLL,
      ST_DRAIN,
      ST_BLANK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      action_type          action;
      logic [BYTE_W-1:0]   char_code;
      logic [BYTE_W-1:0]   color;
      logic [INDEX_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  cursor_position;
      logic [BYTE_W-1:0]   read_char;
      logic [BYTE_W-1:0]   read_attr;
   } rsp_type;

endpackage

// ===== src/text_console_character_writer.sv =====
// Top level: text console engine with screen RAM, cursor and scroll/clear sequencer.
// Put, read and no-op items go through ST_FINISH to the registered result, and the request
// channel stalls until done. A put that scrolls copies rows up (read port, then write port one
// row up), then blanks the bottom row; a clear blanks all ROWS*COLUMNS cells (2000 at 80x25).
// Reset: synchronous; after reset the sequencer blanks all ROWS*COLUMNS cells, one per
// cycle, and stalls the request channel until done. Cursor resets to zero.
`timescale 1ns / 1ps
module text_console_character_writer #(
   parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = tccw_pkg::SCREEN_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tccw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tccw_pkg::rsp_type rsp_data
);

   import tccw_pkg::*;

   localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W  = $clog2(SCREEN_ROWS);

   state_type           state_ff, state_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                owed_ff, owed_in;
   logic                rd_hit_ff, rd_hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [CELL_W-1:0]   ram_rdata;

   logic                accept;
   logic [ADDR_W-1:0]   row_base;
   logic [COL_W:0]      put_col;
   logic [ROW_W:0]      put_row;
   logic                put_we;
   logic [ADDR_W-1:0]   put_addr;
   logic [CELL_W-1:0]   put_data;
   logic                put_scroll;

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = reset || (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign row_base = ADDR_W'(row_ff * SCREEN_COLUMNS);

   // cursor update and cell write for a put
   always_comb begin
      put_col  = {1'b0, col_ff};
      put_row  = {1'b0, row_ff};
      put_we   = 1'b0;
      put_addr = row_base + ADDR_W'(col_ff);
      put_data = {req_data.char_code, req_data.color};
      priority if (req_data.char_code == CHAR_NEWLINE) begin
         put_col = '0;
         put_row = put_row + (ROW_W+1)'(1);
      end else if (req_data.char_code == CHAR_TAB) begin
         put_col = (put_col + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
      end else if (req_data.char_code == CHAR_BACKSPACE) begin
         if (col_ff > COL_W'(2)) begin
            put_col  = put_col - (COL_W+1)'(1);
            put_we   = 1'b1;
            put_addr = row_base + ADDR_W'(col_ff) - ADDR_W'(1);
            put_data = {BLANK_CHAR, req_data.color};
         end
      end else begin
         put_we  = 1'b1;
         put_col = put_col + (COL_W+1)'(1);
      end
      if (put_col >= (COL_W+1)'(SCREEN_COLUMNS)) begin
         put_col = '0;
         put_row = put_row + (ROW_W+1)'(1);
      end
      put_scroll = (put_row >= (ROW_W+1)'(SCREEN_ROWS));
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      owed_in      = owed_ff;
      rd_hit_in    = rd_hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = ptr_ff;
      ram_wdata    = {BLANK_CHAR, BLANK_ATTR};
      ram_raddr    = ADDR_W'(req_data.cell_index);

      // scroll copy: data read last cycle lands one row up
      if (pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = pend_addr_ff;
         ram_wdata = ram_rdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_hit_in = 1'b0;
               unique case (req_data.action)
                  ACT_PUT: begin
                     ram_we    = put_we;
                     ram_waddr = put_addr;
                     ram_wdata = put_data;
                     col_in    = put_col[COL_W-1:0];
                     if (put_scroll) begin
                        row_in   = ROW_W'(SCREEN_ROWS - 1);
                        ptr_in   = ADDR_W'(SCREEN_COLUMNS);
                        state_in = ST_SCROLL;
                     end else begin
                        row_in   = put_row[ROW_W-1:0];
                        state_in = ST_FINISH;
                     end
                  end
                  ACT_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     ptr_in   = '0;
                     owed_in  = 1'b1;
                     state_in = ST_BLANK;
                  end
                  ACT_READ: begin
                     rd_hit_in = (32'(req_data.cell_index) < 32'(CELLS));
                     state_in  = ST_FINISH;
                  end
                  ACT_NOP: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCROLL: begin
            ram_raddr    = ptr_ff;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff - ADDR_W'(SCREEN_COLUMNS);
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            ptr_in   = ADDR_W'(CELLS - SCREEN_COLUMNS);
            owed_in  = 1'b1;
            state_in = ST_BLANK;
         end
         ST_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            ram_wdata = {BLANK_CHAR, BLANK_ATTR};
            if (ptr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = owed_ff ? ST_FINISH : ST_IDLE;
               owed_in  = 1'b0;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_FINISH: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.cursor_position = INDEX_W'(row_ff * SCREEN_COLUMNS + col_ff);
            rsp_data_in.read_char       = rd_hit_ff ? ram_rdata[CELL_W-1:BYTE_W] : '0;
            rsp_data_in.read_attr       = rd_hit_ff ? ram_rdata[BYTE_W-1:0] : '0;
            state_in                    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BLANK;
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         owed_ff      <= 1'b0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         owed_ff      <= owed_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // a finished item must find the output register free
   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> !rsp_valid_ff || !rsp_stall)
      else $error("result produced while output register still held");

   // cursor stays on screen between items
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> ({1'b0, col_ff} < (COL_W+1)'(SCREEN_COLUMNS))
                           && ({1'b0, row_ff} < (ROW_W+1)'(SCREEN_ROWS)))
      else $error("cursor out of range");

   // copy writes only occur while scrolling or draining
   a_pend_scope: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_SCROLL || state_ff == ST_DRAIN)
      else $error("scroll write outside scroll sequence");

   // every accepted item leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("item accepted without work started");

endmodule

// ===== src/tccw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/tb_text_console_character_writer.sv =====
// Self-checking testbench for the text console character writer: directed and random traffic, shadow screen.
`timescale 1ns / 1ps
module tb_text_console_character_writer;
   import tccw_pkg::*;

   localparam int COLS        = SCREEN_COLUMNS_DEF;
   localparam int ROWS        = SCREEN_ROWS_DEF;
   localparam int CELL_COUNT  = COLS * ROWS;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 40;

   // Shadow copy of the screen store and cursor; queues the reply each item should produce.
   class console_shadow;
      logic [CELL_W-1:0] cells [CELL_COUNT];
      int unsigned       col;
      int unsigned       row;
      rsp_type           pending_replies [$];
      int unsigned       errors;

      function new();
         errors = 0;
         blank_screen();
      endfunction

      function void blank_screen();
         foreach (cells[i]) cells[i] = {BLANK_CHAR, BLANK_ATTR};
         col = 0;
         row = 0;
      endfunction

      function void apply_request(req_type item);
         rsp_type reply;
         int      i;
         reply = '0;
         case (item.action)
            ACT_PUT: begin
               case (item.char_code)
                  CHAR_NEWLINE: begin
                     col = 0;
                     row++;
                  end
                  CHAR_TAB: col = (col + 4) & ~32'd3;
                  CHAR_BACKSPACE: begin
                     if (col > 2) begin
                        col--;
                        cells[row * COLS + col] = {BLANK_CHAR, item.color};
                     end
                  end
                  default: begin
                     cells[row * COLS + col] = {item.char_code, item.color};
                     col++;
                  end
               endcase
               if (col >= COLS) begin
                  col = 0;
                  row++;
               end
               if (row >= ROWS) begin
                  for (i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
                  for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
                     cells[i] = {BLANK_CHAR, BLANK_ATTR};
                  row = ROWS - 1;
               end
            end
            ACT_CLEAR: blank_screen();
            ACT_READ: begin
               if (item.cell_index < CELL_COUNT)
                  {reply.read_char, reply.read_attr} = cells[item.cell_index];
            end
            default: ;
         endcase
         reply.cursor_position = INDEX_W'(row * COLS + col);
         pending_replies.push_back(reply);
      endfunction

      function void compare_reply(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            $error("reply with no item outstanding: %h", got);
            errors++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   want.cursor_position, got.cursor_position);
            errors++;
         end
         if (got.read_char !== want.read_char) begin
            $error("read_char: expected %h, got %h", want.read_char, got.read_char);
            errors++;
         end
         if (got.read_attr !== want.read_attr) begin
            $error("read_attr: expected %h, got %h", want.read_attr, got.read_attr);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   console_shadow shadow;
   int unsigned   cycle_count;
   int unsigned   stall_hold;
   bit            burst_phase;

   text_console_character_writer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      cycle_count = 0;
      stall_hold  = 0;
      burst_phase = 1'b0;
   end

   always #2 clock = ~clock;

   function automatic req_type make_req(action_type act, logic [7:0] ch, logic [7:0] attr,
                                        logic [INDEX_W-1:0] idx);
      req_type item;
      item.action     = act;
      item.char_code  = ch;
      item.color      = attr;
      item.cell_index = idx;
      return item;
   endfunction

   function automatic int unsigned req_gap();
      int unsigned r;
      if (burst_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly puts with random content; reads lean toward the cursor row.
   function automatic req_type random_req();
      req_type     item;
      int unsigned r;
      item.char_code  = 8'($urandom);
      item.color      = 8'($urandom);
      item.cell_index = INDEX_W'($urandom);
      r = $urandom_range(0, 999);
      if (r < 5) begin
         item.action = ACT_CLEAR;
      end else if (r < 20) begin
         item.action = ACT_NOP;
      end else if (r < 230) begin
         item.action = ACT_READ;
         r = $urandom_range(0, 99);
         if (r < 40)
            item.cell_index = INDEX_W'(shadow.row * COLS + $urandom_range(0, COLS - 1));
         else if (r < 85)
            item.cell_index = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
         else if (r < 92)
            item.cell_index = INDEX_W'(CELL_COUNT - 1 - $urandom_range(0, COLS - 1));
      end else begin
         item.action = ACT_PUT;
         r = $urandom_range(0, 99);
         if (r < 6)
            item.char_code = CHAR_NEWLINE;
         else if (r < 14)
            item.char_code = CHAR_TAB;
         else if (r < 26)
            item.char_code = CHAR_BACKSPACE;
         else
            while (item.char_code == CHAR_NEWLINE || item.char_code == CHAR_TAB ||
                   item.char_code == CHAR_BACKSPACE)
               item.char_code = 8'($urandom);
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = req_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Reply-side backpressure: runs of open cycles and stalls, mostly short.
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b1;
         case ($urandom_range(0, 19))
            0:       stall_hold = $urandom_range(50, 150);
            1, 2, 3: stall_hold = $urandom_range(3, 15);
            default: stall_hold = $urandom_range(0, 1);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) shadow.apply_request(req_data);
         if (rsp_valid && !rsp_stall) shadow.compare_reply(rsp_data);
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_text_console_character_writer: errors");
         $finish;
      end
   end

   initial begin
      shadow = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: read extremes, backspace limits, tab rounding, newline, nop, clear
      send_item(make_req(ACT_READ, 8'h00, 8'h00, 11'd0));
      send_item(make_req(ACT_READ, 8'hFF, 8'hFF, 11'(CELL_COUNT - 1)));
      send_item(make_req(ACT_READ, 8'h00, 8'h00, 11'(CELL_COUNT)));
      send_item(make_req(ACT_READ, 8'hFF, 8'hFF, 11'h7FF));
      send_item(make_req(ACT_PUT, 8'h41, 8'h00, 11'd0));
      send_item(make_req(ACT_PUT, 8'hFF, 8'hFF, 11'h7FF));
      send_item(make_req(ACT_PUT, CHAR_BACKSPACE, 8'h11, 11'd0));
      send_item(make_req(ACT_PUT, 8'h00, 8'h5A, 11'd0));
      send_item(make_req(ACT_PUT, CHAR_BACKSPACE, 8'hC3, 11'd0));
      send_item(make_req(ACT_READ, 8'h00, 8'h00, 11'd2));
      send_item(make_req(ACT_READ, 8'h00, 8'h00, 11'd1));
      send_item(make_req(ACT_PUT, CHAR_TAB, 8'h00, 11'd0));
      send_item(make_req(ACT_PUT, CHAR_TAB, 8'h00, 11'd0));
      send_item(make_req(ACT_PUT, CHAR_NEWLINE, 8'h00, 11'd0));
      send_item(make_req(ACT_NOP, 8'hA5, 8'h5A, 11'h555));
      send_item(make_req(ACT_READ, 8'h00, 8'h00, 11'd0));
      send_item(make_req(ACT_CLEAR, 8'h00, 8'h00, 11'd0));
      send_item(make_req(ACT_READ, 8'h00, 8'h00, 11'd1));
      send_item(make_req(ACT_PUT, CHAR_BACKSPACE, 8'hEE, 11'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) burst_phase = ($urandom_range(0, 9) < 3);
         send_item(random_req());
      end
      req_valid <= 1'b0;

      while (shadow.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0)
         $display("tb_text_console_character_writer: clean");
      else
         $display("tb_text_console_character_writer: errors");
      $finish;
   end
endmodule
